@@ src/prefix_trie_longest_match_top_macros.svh @@
// assertion macros for the prefix trie block
// used by prefix_trie_longest_match_top; no other dependencies
`ifndef PREFIX_TRIE_LONGEST_MATCH_TOP_MACROS_SVH
`define PREFIX_TRIE_LONGEST_MATCH_TOP_MACROS_SVH

// same-cycle implication, disabled in reset
`define PTLM_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, disabled in reset
`define PTLM_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ src/ptlm_pkg.sv @@
// shared constants, types and codes for the prefix trie block
// no dependencies
package ptlm_pkg;

   localparam int POOL_NODES = 4096;
   localparam int ADDR_BITS  = 128;
   localparam int HALF_W     = 64;
   localparam int NODE_W     = $clog2(POOL_NODES);
   localparam int FREE_W     = NODE_W + 1;
   localparam int LEN_W      = 8;
   localparam int CNT_W      = $clog2(ADDR_BITS + 1);
   localparam int SITE_W     = 16;
   localparam int SCOPE_W    = 8;
   localparam int STATUS_W   = 2;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK   = 2'd0,
      STATUS_MISS = 2'd1,
      STATUS_FULL = 2'd2
   } status_type;

   typedef enum logic {
      OP_INSERT = 1'b0,
      OP_LOOKUP = 1'b1
   } op_type;

   typedef enum logic {
      ST_IDLE,
      ST_WALK
   } state_type;

   // where the current node's record comes from
   typedef enum logic [1:0] {
      SRC_ROOT,
      SRC_MEM,
      SRC_ZERO
   } src_type;

   typedef struct packed {
      logic [NODE_W-1:0]  link1;
      logic [NODE_W-1:0]  link0;
      logic               marked;
      logic [SITE_W-1:0]  site;
      logic [SCOPE_W-1:0] scope;
   } node_rec_type;

   typedef struct packed {
      logic              en;
      logic [NODE_W-1:0] addr;
      node_rec_type      data;
   } ram_wr_type;

   typedef struct packed {
      logic              en;
      logic [NODE_W-1:0] addr;
   } ram_rd_type;

endpackage

@@ src/ptlm_if.sv @@
// request and response channel interfaces of the prefix trie block
// depends on ptlm_pkg
interface ptlm_req_if;
   logic                           valid;
   logic                           ready;
   logic                           req_type;
   logic [ptlm_pkg::HALF_W-1:0]    addr_hi;
   logic [ptlm_pkg::HALF_W-1:0]    addr_lo;
   logic [ptlm_pkg::LEN_W-1:0]     bit_len;
   logic [ptlm_pkg::SCOPE_W-1:0]   scope_len;
   logic [ptlm_pkg::SITE_W-1:0]    site_id;

   modport source (output valid, req_type, addr_hi, addr_lo, bit_len, scope_len, site_id,
                   input ready);
   modport sink   (input valid, req_type, addr_hi, addr_lo, bit_len, scope_len, site_id,
                   output ready);
endinterface

interface ptlm_rsp_if;
   logic                           valid;
   logic                           ready;
   logic [ptlm_pkg::STATUS_W-1:0]  status;
   logic [ptlm_pkg::SITE_W-1:0]    match_site;
   logic [ptlm_pkg::SCOPE_W-1:0]   match_scope;

   modport source (output valid, status, match_site, match_scope, input ready);
   modport sink   (input valid, status, match_site, match_scope, output ready);
endinterface

@@ src/ptlm_node_ram.sv @@
// node pool memory: one write port, one registered read port
// depends on ptlm_pkg
module ptlm_node_ram (
   input  logic                   clock,
   input  ptlm_pkg::ram_wr_type   wr_port,
   input  ptlm_pkg::ram_rd_type   rd_port,
   output ptlm_pkg::node_rec_type rd_data
);

   ptlm_pkg::node_rec_type node_mem [ptlm_pkg::POOL_NODES];
   ptlm_pkg::node_rec_type rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_port.en) begin
         node_mem[wr_port.addr] <= wr_port.data;
      end
   end

   // read port, data held until the next enabled read
   always_ff @(posedge clock) begin
      if (rd_port.en) begin
         rd_data_ff <= node_mem[rd_port.addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ src/prefix_trie_longest_match_top.sv @@
// Binary trie for longest-prefix match on 128-bit addresses.
// Depends on ptlm_pkg, ptlm_if, ptlm_node_ram and the assertion macro header.
//
// Use: requests arrive on req_if (valid/ready); a transfer carries an insert
// (req_type 0: prefix, bit_len, scope_len, site_id) or a lookup (req_type 1).
// Each request yields one response transfer on rsp_if (status, match_site, match_scope).
// Timing: the request address sits in a shift register that hands out one
// walk bit per cycle; each trie level is one walk step, paced by the single
// registered read of the node memory. A request walks the root and then
// one level per walked bit (bit_len saturated at 128); its response is
// registered at the end, and a new request is taken only once the walk
// of the last one is done, while that response may still wait.
// Lookups stop early at the first missing child; inserts stop on pool full.
// The root node lives in flip-flops, the other nodes in the memory; a new
// node is written out before anything can read it, so no clearing pass is
// needed and the block takes requests straight after reset.
// Reset (synchronous) empties the trie and the response register.
// If the receiver stalls, one finished response waits in the output register
// while the next request is accepted and walked; a walk that finishes while
// that response still waits holds until it is taken.
`include "prefix_trie_longest_match_top_macros.svh"

module prefix_trie_longest_match_top (
   input  logic        clock,
   input  logic        reset,
   ptlm_req_if.sink    req_if,
   ptlm_rsp_if.source  rsp_if
);

   // control state
   ptlm_pkg::state_type              state_ff, state_in;
   ptlm_pkg::op_type                 op_ff, op_in;
   ptlm_pkg::src_type                src_ff, src_in;
   logic [ptlm_pkg::CNT_W-1:0]       cnt_ff, cnt_in;
   logic [ptlm_pkg::NODE_W-1:0]      cur_ff, cur_in;
   logic [ptlm_pkg::FREE_W-1:0]      next_free_ff, next_free_in;
   logic                             hit_ff, hit_in;
   ptlm_pkg::node_rec_type           root_ff, root_in;
   logic                             rsp_valid_ff, rsp_valid_in;

   // payload state
   logic [ptlm_pkg::ADDR_BITS-1:0]   shift_ff, shift_in;
   logic [ptlm_pkg::SITE_W-1:0]      site_ff, site_in;
   logic [ptlm_pkg::SCOPE_W-1:0]     scope_ff, scope_in;
   logic [ptlm_pkg::SITE_W-1:0]      best_site_ff, best_site_in;
   logic [ptlm_pkg::SCOPE_W-1:0]     best_scope_ff, best_scope_in;
   ptlm_pkg::status_type             rsp_status_ff, rsp_status_in;
   logic [ptlm_pkg::SITE_W-1:0]      rsp_site_ff, rsp_site_in;
   logic [ptlm_pkg::SCOPE_W-1:0]     rsp_scope_ff, rsp_scope_in;

   // walk signals
   ptlm_pkg::node_rec_type           rec;
   ptlm_pkg::node_rec_type           new_rec;
   ptlm_pkg::node_rec_type           ram_rd_data;
   ptlm_pkg::ram_wr_type             ram_wr;
   ptlm_pkg::ram_rd_type             ram_rd;
   logic [2*ptlm_pkg::HALF_W-1:0]    addr_full;
   logic [ptlm_pkg::CNT_W-1:0]       len_sat;
   logic [ptlm_pkg::NODE_W-1:0]      nxt;
   logic                             walk_bit;
   logic                             at_end;
   logic                             no_child;
   logic                             pool_full;
   logic                             finish;
   logic                             advance;
   logic                             walk_done;
   logic                             req_xfer;
   logic                             wr_needed;
   logic                             hit_now;
   logic [ptlm_pkg::SITE_W-1:0]      site_now;
   logic [ptlm_pkg::SCOPE_W-1:0]     scope_now;
   ptlm_pkg::status_type             fin_status;
   logic [ptlm_pkg::SITE_W-1:0]      fin_site;
   logic [ptlm_pkg::SCOPE_W-1:0]     fin_scope;

   ptlm_node_ram u_node_ram (
      .clock   (clock),
      .wr_port (ram_wr),
      .rd_port (ram_rd),
      .rd_data (ram_rd_data)
   );

   // request decode
   assign addr_full = {req_if.addr_hi, req_if.addr_lo};
   assign len_sat   = (req_if.bit_len > ptlm_pkg::LEN_W'(ptlm_pkg::ADDR_BITS)) ?
                      ptlm_pkg::CNT_W'(ptlm_pkg::ADDR_BITS) :
                      ptlm_pkg::CNT_W'(req_if.bit_len);
   assign req_xfer  = req_if.valid && req_if.ready;

   // record of the current node
   always_comb begin
      case (src_ff)
         ptlm_pkg::SRC_ROOT: rec = root_ff;
         ptlm_pkg::SRC_MEM:  rec = ram_rd_data;
         default:            rec = '0;
      endcase
   end

   // one trie level per cycle; a finished walk holds while a response still waits
   assign walk_bit  = shift_ff[ptlm_pkg::ADDR_BITS-1];
   assign nxt       = walk_bit ? rec.link1 : rec.link0;
   assign at_end    = (cnt_ff == '0);
   assign no_child  = (nxt == '0);
   assign pool_full = (next_free_ff >= ptlm_pkg::FREE_W'(ptlm_pkg::POOL_NODES));

   // deepest marked node so far, including this one
   assign hit_now   = hit_ff || rec.marked;
   assign site_now  = rec.marked ? rec.site  : best_site_ff;
   assign scope_now = rec.marked ? rec.scope : best_scope_ff;

   // end of walk and its result
   always_comb begin
      if (op_ff == ptlm_pkg::OP_INSERT) begin
         finish     = at_end || (no_child && pool_full);
         fin_status = at_end ? ptlm_pkg::STATUS_OK : ptlm_pkg::STATUS_FULL;
         fin_site   = '0;
         fin_scope  = '0;
      end else begin
         finish     = at_end || no_child;
         fin_status = hit_now ? ptlm_pkg::STATUS_OK : ptlm_pkg::STATUS_MISS;
         fin_site   = hit_now ? site_now  : '0;
         fin_scope  = hit_now ? scope_now : '0;
      end
   end

   assign advance   = (state_ff == ptlm_pkg::ST_WALK) &&
                      (!finish || !rsp_valid_ff || rsp_if.ready);
   assign walk_done = advance && finish;

   // insert write-back of the current node: mark, link a new child, or flush
   always_comb begin
      new_rec = rec;
      if (at_end) begin
         new_rec.marked = 1'b1;
         new_rec.site   = site_ff;
         new_rec.scope  = scope_ff;
      end else if (no_child && !pool_full) begin
         if (walk_bit) begin
            new_rec.link1 = next_free_ff[ptlm_pkg::NODE_W-1:0];
         end else begin
            new_rec.link0 = next_free_ff[ptlm_pkg::NODE_W-1:0];
         end
      end
   end

   assign wr_needed = advance && (op_ff == ptlm_pkg::OP_INSERT) && (at_end || no_child);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ptlm_pkg::ST_IDLE: begin
            if (req_xfer) begin
               state_in = ptlm_pkg::ST_WALK;
            end
         end
         ptlm_pkg::ST_WALK: begin
            if (walk_done) begin
               state_in = ptlm_pkg::ST_IDLE;
            end
         end
         default: state_in = ptlm_pkg::ST_IDLE;
      endcase
   end

   // outputs: handshake and memory ports
   always_comb begin
      req_if.ready = (state_ff == ptlm_pkg::ST_IDLE);
      ram_wr.en    = wr_needed && (cur_ff != '0);
      ram_wr.addr  = cur_ff;
      ram_wr.data  = new_rec;
      ram_rd.en    = advance && !at_end && !no_child;
      ram_rd.addr  = nxt;
   end

   assign rsp_if.valid       = rsp_valid_ff;
   assign rsp_if.status      = rsp_status_ff;
   assign rsp_if.match_site  = rsp_site_ff;
   assign rsp_if.match_scope = rsp_scope_ff;

   // datapath next values
   always_comb begin
      op_in         = op_ff;
      src_in        = src_ff;
      cnt_in        = cnt_ff;
      cur_in        = cur_ff;
      next_free_in  = next_free_ff;
      hit_in        = hit_ff;
      root_in       = root_ff;
      shift_in      = shift_ff;
      site_in       = site_ff;
      scope_in      = scope_ff;
      best_site_in  = best_site_ff;
      best_scope_in = best_scope_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_if.ready;
      rsp_status_in = rsp_status_ff;
      rsp_site_in   = rsp_site_ff;
      rsp_scope_in  = rsp_scope_ff;

      // load a new request
      if (req_xfer) begin
         op_in    = ptlm_pkg::op_type'(req_if.req_type);
         src_in   = ptlm_pkg::SRC_ROOT;
         cnt_in   = len_sat;
         cur_in   = '0;
         hit_in   = 1'b0;
         shift_in = addr_full[2*ptlm_pkg::HALF_W-1 -: ptlm_pkg::ADDR_BITS];
         site_in  = req_if.site_id;
         scope_in = req_if.scope_len;
      end

      if (advance) begin
         hit_in        = hit_now;
         best_site_in  = site_now;
         best_scope_in = scope_now;
         if (wr_needed && (cur_ff == '0)) begin
            root_in = new_rec;
         end
         if (finish) begin
            rsp_valid_in  = 1'b1;
            rsp_status_in = fin_status;
            rsp_site_in   = fin_site;
            rsp_scope_in  = fin_scope;
         end else begin
            shift_in = {shift_ff[ptlm_pkg::ADDR_BITS-2:0], 1'b0};
            cnt_in   = cnt_ff - ptlm_pkg::CNT_W'(1);
            if (no_child) begin
               // allocate a fresh node, its record is all zero
               cur_in       = next_free_ff[ptlm_pkg::NODE_W-1:0];
               next_free_in = next_free_ff + ptlm_pkg::FREE_W'(1);
               src_in       = ptlm_pkg::SRC_ZERO;
            end else begin
               cur_in = nxt;
               src_in = ptlm_pkg::SRC_MEM;
            end
         end
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ptlm_pkg::ST_IDLE;
         op_ff        <= ptlm_pkg::OP_INSERT;
         src_ff       <= ptlm_pkg::SRC_ROOT;
         cnt_ff       <= '0;
         cur_ff       <= '0;
         next_free_ff <= ptlm_pkg::FREE_W'(1);
         hit_ff       <= 1'b0;
         root_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         op_ff        <= op_in;
         src_ff       <= src_in;
         cnt_ff       <= cnt_in;
         cur_ff       <= cur_in;
         next_free_ff <= next_free_in;
         hit_ff       <= hit_in;
         root_ff      <= root_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      shift_ff      <= shift_in;
      site_ff       <= site_in;
      scope_ff      <= scope_in;
      best_site_ff  <= best_site_in;
      best_scope_ff <= best_scope_in;
      rsp_status_ff <= rsp_status_in;
      rsp_site_ff   <= rsp_site_in;
      rsp_scope_ff  <= rsp_scope_in;
   end

   // checks
   `PTLM_ASSERT_IMPLY(a_root_not_in_ram, clock, reset, (state_ff == ptlm_pkg::ST_WALK) && (src_ff == ptlm_pkg::SRC_MEM), cur_ff != '0, "root node record taken from memory")
   `PTLM_ASSERT_IMPLY(a_ram_wr_not_root, clock, reset, ram_wr.en, ram_wr.addr != '0, "memory write aimed at the root node")
   `PTLM_ASSERT_IMPLY(a_pool_bound, clock, reset, 1'b1, next_free_ff <= ptlm_pkg::FREE_W'(ptlm_pkg::POOL_NODES), "free pointer past the pool")
   `PTLM_ASSERT_NEXT(a_done_gives_rsp, clock, reset, walk_done, rsp_valid_ff && (state_ff == ptlm_pkg::ST_IDLE), "finished walk without a response")

endmodule
